>>> sv/mm_pkg.sv
// Shared types and constants of the matrix multiply core.
package mm_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // Dimension registers reset to this value
  localparam logic [3:0] DIM_RESET = 4'd8;

  // Saturation bound of the dot-product accumulator, +/-2^62
  localparam logic signed [65:0] ACC_LIMIT = 66'sh0_4000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CALC  = 3'b010,
    ST_DRAIN = 3'b100
  } mm_state_e;

  // Control that travels along the cell chain with each A element
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm_tok_t;

endpackage

>>> sv/mm_if.sv
// Stream interfaces for element loads and result items.
interface mm_in_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [ELEM_WIDTH-1:0] element_value;

  modport source (output valid, req_type, element_value, input ready);
  modport sink   (input valid, req_type, element_value, output ready);
endinterface

interface mm_out_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] product_value;
  logic                         last_result;

  modport source (output valid, product_value, last_result, input ready);
  modport sink   (input valid, product_value, last_result, output ready);
endinterface

>>> sv/mm_cell.sv
// One column cell: holds a column of B, multiplies the passing A element, accumulates.
module mm_cell #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_WIDTH  = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          b_we_i,
  input  logic [$clog2(MAX_DIM)-1:0]    b_idx_i,
  input  logic signed [ELEM_WIDTH-1:0]  b_data_i,
  input  mm_pkg::mm_tok_t               tok_i,
  input  logic [$clog2(MAX_DIM)-1:0]    k_i,
  input  logic signed [ELEM_WIDTH-1:0]  a_i,
  output mm_pkg::mm_tok_t               tok_o,
  output logic [$clog2(MAX_DIM)-1:0]    k_o,
  output logic signed [ELEM_WIDTH-1:0]  a_o,
  output logic                          done_o,
  output logic signed [ACC_WIDTH-1:0]   acc_o
);

  localparam int KW  = $clog2(MAX_DIM);
  localparam int PRW = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH-1:0] b_col_q [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] b_sel;

  mm_pkg::mm_tok_t              tok_q;
  logic [KW-1:0]                k_q;
  logic signed [ELEM_WIDTH-1:0] a_q;
  logic signed [PRW-1:0]        prod_q;

  logic signed [ACC_WIDTH-1:0]  acc_q, acc_d, acc_base;
  logic signed [ACC_WIDTH:0]    sum;
  logic signed [65:0]           sum_x, sum_c;
  logic                         done_q;

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_col_q[b_idx_i] <= b_data_i;
    end
  end

  assign b_sel = b_col_q[k_i];

  // Stage 1: product, and the A element moves on to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_i;
    a_q    <= a_i;
    prod_q <= a_i * b_sel;
  end

  // Stage 2: saturating accumulate, restarted on the first element of a row
  always_comb begin
    acc_base = tok_q.first ? '0 : acc_q;
    sum      = {acc_base[ACC_WIDTH-1], acc_base}
             + {{(ACC_WIDTH + 1 - PRW){prod_q[PRW-1]}}, prod_q};
    sum_x    = {{(65 - ACC_WIDTH){sum[ACC_WIDTH]}}, sum};
    if (sum_x > mm_pkg::ACC_LIMIT) begin
      sum_c = mm_pkg::ACC_LIMIT;
    end else if (sum_x < -mm_pkg::ACC_LIMIT) begin
      sum_c = -mm_pkg::ACC_LIMIT;
    end else begin
      sum_c = sum_x;
    end
    acc_d = sum_c[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (tok_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tok_q.valid & tok_q.last;
    end
  end

  assign tok_o  = tok_q;
  assign k_o    = k_q;
  assign a_o    = a_q;
  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> sv/mm_seq.sv
// Load control, A memory and row sequencer that feeds the cell chain.
module mm_seq #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_r_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_n_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]      dim_c_i,
  input  logic                              cfg_clr_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [ELEM_WIDTH-1:0]      elem_i,
  input  logic                              last_pop_i,
  output logic                              start_o,
  output logic                              b_we_o,
  output logic [$clog2(MAX_DIM)-1:0]        b_idx_o,
  output logic [$clog2(MAX_DIM)-1:0]        b_col_o,
  output logic signed [ELEM_WIDTH-1:0]      b_data_o,
  output mm_pkg::mm_tok_t                   tok_o,
  output logic [$clog2(MAX_DIM)-1:0]        k_o,
  output logic signed [ELEM_WIDTH-1:0]      a_o
);

  localparam int KW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];

  mm_pkg::mm_state_e state_q, state_d;

  logic [CW-1:0] a_cnt_q, b_cnt_q, rn, nc;
  logic [KW-1:0] b_k_q, b_j_q;
  logic [KW-1:0] row_q, t_q;
  logic [PW-1:0] addr_q;
  logic [DW-1:0] p_len;

  logic accept, a_wr, b_wr, b_done, issue, row_end, calc_end;

  mm_pkg::mm_tok_t              tok_q;
  logic [KW-1:0]                tok_k_q;
  logic signed [ELEM_WIDTH-1:0] a_rd_q;

  assign rn     = CW'(dim_r_i * dim_n_i);
  assign nc     = CW'(dim_n_i * dim_c_i);
  assign p_len  = (dim_n_i > dim_c_i) ? dim_n_i : dim_c_i;

  assign in_ready_o = (state_q == mm_pkg::ST_LOAD);
  assign accept     = in_valid_i & in_ready_o;
  assign a_wr       = accept & ~req_type_i & (a_cnt_q < rn);
  assign b_wr       = accept & req_type_i;
  assign b_done     = b_wr & ((b_cnt_q + CW'(1)) == nc);

  assign issue    = (state_q == mm_pkg::ST_CALC) & (DW'(t_q) < dim_n_i);
  assign row_end  = (DW'(t_q) == (p_len - DW'(1)));
  assign calc_end = row_end & (DW'(row_q) == (dim_r_i - DW'(1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      mm_pkg::ST_LOAD:  if (b_done)     state_d = mm_pkg::ST_CALC;
      mm_pkg::ST_CALC:  if (calc_end)   state_d = mm_pkg::ST_DRAIN;
      mm_pkg::ST_DRAIN: if (last_pop_i) state_d = mm_pkg::ST_LOAD;
      default:                          state_d = mm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_LOAD;
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      b_k_q   <= '0;
      b_j_q   <= '0;
      row_q   <= '0;
      t_q     <= '0;
      addr_q  <= '0;
      tok_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_clr_i || b_done) begin
        a_cnt_q <= '0;
        b_cnt_q <= '0;
        b_k_q   <= '0;
        b_j_q   <= '0;
      end else begin
        if (a_wr) begin
          a_cnt_q <= a_cnt_q + CW'(1);
        end
        if (b_wr) begin
          b_cnt_q <= b_cnt_q + CW'(1);
          if (DW'(b_j_q) == (dim_c_i - DW'(1))) begin
            b_j_q <= '0;
            b_k_q <= b_k_q + KW'(1);
          end else begin
            b_j_q <= b_j_q + KW'(1);
          end
        end
      end
      if (b_done) begin
        row_q  <= '0;
        t_q    <= '0;
        addr_q <= '0;
      end else if (state_q == mm_pkg::ST_CALC) begin
        if (row_end) begin
          t_q   <= '0;
          row_q <= row_q + KW'(1);
        end else begin
          t_q <= t_q + KW'(1);
        end
        if (issue) begin
          addr_q <= addr_q + PW'(1);
        end
      end
      tok_q.valid <= issue;
      tok_q.first <= (t_q == '0);
      tok_q.last  <= (DW'(t_q) == (dim_n_i - DW'(1)));
    end
  end

  // A is stored row-major, so a row is read at consecutive addresses
  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      a_mem[a_cnt_q[PW-1:0]] <= elem_i;
    end
    a_rd_q  <= a_mem[addr_q];
    tok_k_q <= t_q;
  end

  assign start_o  = b_done;
  assign b_we_o   = b_wr;
  assign b_idx_o  = b_k_q;
  assign b_col_o  = b_j_q;
  assign b_data_o = elem_i;
  assign tok_o    = tok_q;
  assign k_o      = tok_k_q;
  assign a_o      = a_rd_q;

endmodule

>>> sv/mm_collect.sv
// Picks finished dot products off the chain, rounds, saturates and queues them.
module mm_collect #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_WIDTH  = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]  dim_r_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]  dim_c_i,
  input  logic                          done_i [MAX_DIM],
  input  logic signed [ACC_WIDTH-1:0]   acc_i [MAX_DIM],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ELEM_WIDTH-1:0]  product_o,
  output logic                          last_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int FRAC  = ELEM_WIDTH / 2;
  localparam int QW    = ACC_WIDTH + 1 - FRAC;
  localparam logic [ACC_WIDTH:0] HALF = (ACC_WIDTH + 1)'(1) << (FRAC - 1);
  localparam logic signed [QW-1:0] QHI =
    {{(QW - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] QLO =
    {{(QW - ELEM_WIDTH + 1){1'b1}}, {(ELEM_WIDTH - 1){1'b0}}};

  logic [ELEM_WIDTH:0] fifo_mem [DEPTH];

  logic                        sel_vld, sel_vld_q;
  logic signed [ACC_WIDTH-1:0] sel_acc, sel_acc_q;
  logic signed [ACC_WIDTH:0]   rnd;
  logic signed [QW-1:0]        q;
  logic signed [ELEM_WIDTH-1:0] res;
  logic [CW-1:0]               total, wr_ptr_q, rd_ptr_q;
  logic                        res_last, pop_load;
  logic                        out_valid_q;
  logic [ELEM_WIDTH:0]         out_q;

  assign total = CW'(dim_r_i * dim_c_i);

  // Row timing keeps at most one active column finishing per cycle
  always_comb begin
    sel_vld = 1'b0;
    sel_acc = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (done_i[j] && (j < int'(dim_c_i))) begin
        sel_vld = 1'b1;
        sel_acc = sel_acc | acc_i[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
    end else begin
      sel_vld_q <= sel_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_acc_q <= sel_acc;
  end

  // Round to nearest, ties up: add half, then arithmetic shift
  always_comb begin
    rnd = {sel_acc_q[ACC_WIDTH-1], sel_acc_q} + $signed(HALF);
    q   = rnd[ACC_WIDTH:FRAC];
    if (q > QHI) begin
      res = QHI[ELEM_WIDTH-1:0];
    end else if (q < QLO) begin
      res = QLO[ELEM_WIDTH-1:0];
    end else begin
      res = q[ELEM_WIDTH-1:0];
    end
  end

  assign res_last = (wr_ptr_q == (total - CW'(1)));
  assign pop_load = (rd_ptr_q != wr_ptr_q) & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i) begin
    if (sel_vld_q) begin
      fifo_mem[wr_ptr_q[PW-1:0]] <= {res_last, res};
    end
    if (pop_load) begin
      out_q <= fifo_mem[rd_ptr_q[PW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        wr_ptr_q <= '0;
        rd_ptr_q <= '0;
      end else begin
        if (sel_vld_q) begin
          wr_ptr_q <= wr_ptr_q + CW'(1);
        end
        if (pop_load) begin
          rd_ptr_q <= rd_ptr_q + CW'(1);
        end
      end
      out_valid_q <= pop_load | (out_valid_q & ~out_ready_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = out_q[ELEM_WIDTH-1:0];
  assign last_o      = out_q[ELEM_WIDTH];

endmodule

>>> sv/matrix_multiply_core.sv
// Input loads are accepted back to back while the core is in its load state.
// Results: one per cycle per row when cols_b >= inner_dim and out ready is not held low;
// each row is paced by the A element stream that walks the chain of column cells.
// Input is held off from the final B load until the last result item is taken.
// Reset: async, clears counters and control; dimension registers return to 8.
// A and B stores are not cleared and hold nothing valid until loaded.
module matrix_multiply_core #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mm_in_if.sink       in_i,
  mm_out_if.source    out_o
);

  localparam int KW     = $clog2(MAX_DIM);
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int AW_RAW = 2 * ELEM_WIDTH + $clog2(MAX_DIM);
  localparam int AW     = (AW_RAW > 64) ? 64 : AW_RAW;

  logic [3:0]    rows_q, inner_q, cols_q;
  logic [1:0]    reg_idx;
  logic          cfg_wr, cfg_clr;
  logic [DW-1:0] dim_r, dim_n, dim_c;

  logic                         start, b_we, last_pop;
  logic [KW-1:0]                b_idx, b_col;
  logic signed [ELEM_WIDTH-1:0] b_data;

  mm_pkg::mm_tok_t              tok  [MAX_DIM];
  logic [KW-1:0]                k    [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] a    [MAX_DIM];
  logic                         done [MAX_DIM];
  logic signed [AW-1:0]         acc  [MAX_DIM];

  function automatic logic [DW-1:0] clamp_dim(input logic [3:0] v);
    logic [DW-1:0] r;
    if (v == 4'd0) begin
      r = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_clr = cfg_wr & ((reg_idx == mm_pkg::REG_ROWS_A) ||
                             (reg_idx == mm_pkg::REG_INNER_DIM) ||
                             (reg_idx == mm_pkg::REG_COLS_B));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mm_pkg::DIM_RESET;
      inner_q <= mm_pkg::DIM_RESET;
      cols_q  <= mm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mm_pkg::REG_ROWS_A:    rows_q  <= pwdata[3:0];
        mm_pkg::REG_INNER_DIM: inner_q <= pwdata[3:0];
        mm_pkg::REG_COLS_B:    cols_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mm_pkg::REG_ROWS_A:    prdata = {28'd0, rows_q};
      mm_pkg::REG_INNER_DIM: prdata = {28'd0, inner_q};
      mm_pkg::REG_COLS_B:    prdata = {28'd0, cols_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign dim_r = clamp_dim(rows_q);
  assign dim_n = clamp_dim(inner_q);
  assign dim_c = clamp_dim(cols_q);

  assign last_pop = out_o.valid & out_o.ready & out_o.last_result;

  mm_seq #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dim_r_i    (dim_r),
    .dim_n_i    (dim_n),
    .dim_c_i    (dim_c),
    .cfg_clr_i  (cfg_clr),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .req_type_i (in_i.req_type),
    .elem_i     (in_i.element_value),
    .last_pop_i (last_pop),
    .start_o    (start),
    .b_we_o     (b_we),
    .b_idx_o    (b_idx),
    .b_col_o    (b_col),
    .b_data_o   (b_data),
    .tok_o      (tok[0]),
    .k_o        (k[0]),
    .a_o        (a[0])
  );

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    if (j < MAX_DIM - 1) begin : g_mid
      mm_cell #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (AW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .b_we_i   (b_we && (b_col == KW'(j))),
        .b_idx_i  (b_idx),
        .b_data_i (b_data),
        .tok_i    (tok[j]),
        .k_i      (k[j]),
        .a_i      (a[j]),
        .tok_o    (tok[j+1]),
        .k_o      (k[j+1]),
        .a_o      (a[j+1]),
        .done_o   (done[j]),
        .acc_o    (acc[j])
      );
    end else begin : g_end
      mm_cell #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (AW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .b_we_i   (b_we && (b_col == KW'(j))),
        .b_idx_i  (b_idx),
        .b_data_i (b_data),
        .tok_i    (tok[j]),
        .k_i      (k[j]),
        .a_i      (a[j]),
        .tok_o    (),
        .k_o      (),
        .a_o      (),
        .done_o   (done[j]),
        .acc_o    (acc[j])
      );
    end
  end

  mm_collect #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .ACC_WIDTH  (AW)
  ) u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .dim_r_i     (dim_r),
    .dim_c_i     (dim_c),
    .done_i      (done),
    .acc_i       (acc),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .product_o   (out_o.product_value),
    .last_o      (out_o.last_result)
  );

endmodule
